@@ rtl/core/vrpd_pkg.sv @@
`default_nettype none
package vrpd_pkg;

  // gain and period formats
  localparam int GAIN_W     = 18;
  localparam int GAIN_FRAC  = 16;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // register reset values
  localparam logic [GAIN_W-1:0]   KP_RST     = 18'd35081;
  localparam logic [GAIN_W-1:0]   KI_RST     = 18'd8743;
  localparam logic [GAIN_W-1:0]   KD_RST     = 18'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP         = 2'd0,
    REG_KI         = 2'd1,
    REG_KD         = 2'd2,
    REG_PWM_PERIOD = 2'd3
  } reg_idx_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_TGT,
    ST_ERR,
    ST_MP,
    ST_MI,
    ST_MD,
    ST_ACC,
    ST_DUTY,
    ST_PWM,
    ST_OUT
  } state_t;

  // operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MAC_P,
    MAC_I,
    MAC_D,
    MAC_PWM
  } mac_sel_t;

  // how the target duty is formed
  typedef enum logic [1:0] {
    TS_ZERO,
    TS_FULL,
    TS_QUOT
  } tsel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_step;
    logic     chk;
    logic     div_step;
    logic     tgt;
    logic     err;
    logic     mul_en;
    mac_sel_t mac_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     duty_upd;
    logic     out_ld;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/vrpd_if.sv @@
`default_nettype none
// measurement channel
interface vrpd_in_if #(
  parameter int VOLT_BITS = 17
);
  logic                 valid;
  logic                 ready;
  logic [VOLT_BITS-1:0] meas_volt;
  logic [VOLT_BITS-1:0] goal_volt;

  modport source (output valid, output meas_volt, output goal_volt, input ready);
  modport sink   (input valid, input meas_volt, input goal_volt, output ready);
endinterface

// result channel
interface vrpd_out_if #(
  parameter int FRAC_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [FRAC_BITS:0]            duty_level;
  logic [FRAC_BITS:0]            target_duty;
  logic [vrpd_pkg::PERIOD_W-1:0] pulse_width;
  logic                          clamped;

  modport source (output valid, output duty_level, output target_duty,
                  output pulse_width, output clamped, input ready);
  modport sink   (input valid, input duty_level, input target_duty,
                  input pulse_width, input clamped, output ready);
endinterface
`default_nettype wire

@@ rtl/core/vrpd_ctrl.sv @@
`default_nettype none
module vrpd_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           out_ready,
  output logic                out_valid,
  output vrpd_pkg::cmd_t      cmd
);

  localparam int DW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(DW);

  vrpd_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             cnt_last;
  logic             out_ok;

  assign cnt_last  = (cnt_r == CNT_W'(DW - 1));
  assign out_ok    = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vrpd_pkg::ST_IDLE: if (in_valid) state_nxt = vrpd_pkg::ST_MUL;
      vrpd_pkg::ST_MUL:  if (cnt_last) state_nxt = vrpd_pkg::ST_CHK;
      vrpd_pkg::ST_CHK:  state_nxt = vrpd_pkg::ST_DIV;
      vrpd_pkg::ST_DIV:  if (cnt_last) state_nxt = vrpd_pkg::ST_TGT;
      vrpd_pkg::ST_TGT:  state_nxt = vrpd_pkg::ST_ERR;
      vrpd_pkg::ST_ERR:  state_nxt = vrpd_pkg::ST_MP;
      vrpd_pkg::ST_MP:   state_nxt = vrpd_pkg::ST_MI;
      vrpd_pkg::ST_MI:   state_nxt = vrpd_pkg::ST_MD;
      vrpd_pkg::ST_MD:   state_nxt = vrpd_pkg::ST_ACC;
      vrpd_pkg::ST_ACC:  state_nxt = vrpd_pkg::ST_DUTY;
      vrpd_pkg::ST_DUTY: state_nxt = vrpd_pkg::ST_PWM;
      vrpd_pkg::ST_PWM:  state_nxt = vrpd_pkg::ST_OUT;
      vrpd_pkg::ST_OUT:  if (out_ok) state_nxt = vrpd_pkg::ST_IDLE;
      default:           state_nxt = vrpd_pkg::ST_IDLE;
    endcase
  end

  // step counter for multiply and divide
  always_comb begin
    cnt_nxt = '0;
    if ((state_r == vrpd_pkg::ST_MUL || state_r == vrpd_pkg::ST_DIV) && !cnt_last) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      vrpd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      vrpd_pkg::ST_MUL:  cmd.mul_step = 1'b1;
      vrpd_pkg::ST_CHK:  cmd.chk      = 1'b1;
      vrpd_pkg::ST_DIV:  cmd.div_step = 1'b1;
      vrpd_pkg::ST_TGT:  cmd.tgt      = 1'b1;
      vrpd_pkg::ST_ERR:  cmd.err      = 1'b1;
      vrpd_pkg::ST_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mac_sel = vrpd_pkg::MAC_P;
      end
      vrpd_pkg::ST_MI: begin
        cmd.mul_en  = 1'b1;
        cmd.mac_sel = vrpd_pkg::MAC_I;
        cmd.acc_clr = 1'b1;
      end
      vrpd_pkg::ST_MD: begin
        cmd.mul_en  = 1'b1;
        cmd.mac_sel = vrpd_pkg::MAC_D;
        cmd.acc_add = 1'b1;
      end
      vrpd_pkg::ST_ACC:  cmd.acc_add  = 1'b1;
      vrpd_pkg::ST_DUTY: cmd.duty_upd = 1'b1;
      vrpd_pkg::ST_PWM: begin
        cmd.mul_en  = 1'b1;
        cmd.mac_sel = vrpd_pkg::MAC_PWM;
      end
      vrpd_pkg::ST_OUT:  cmd.out_ld = out_ok;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vrpd_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/vrpd_dp.sv @@
`default_nettype none
module vrpd_dp #(
  parameter int FRAC_BITS = 16,
  parameter int VOLT_BITS = 17
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire vrpd_pkg::cmd_t                  cmd,
  input  wire logic                            cfg_we,
  input  wire logic [vrpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vrpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [VOLT_BITS-1:0]            meas_volt,
  input  wire logic [VOLT_BITS-1:0]            goal_volt,
  output logic [FRAC_BITS:0]                   duty_level,
  output logic [FRAC_BITS:0]                   target_duty,
  output logic [vrpd_pkg::PERIOD_W-1:0]        pulse_width,
  output logic                                 clamped
);

  localparam int DW  = FRAC_BITS + 1;           // duty width
  localparam int EW  = FRAC_BITS + 2;           // error width, signed
  localparam int PW  = VOLT_BITS + DW;          // set * duty width
  localparam int AWD = vrpd_pkg::GAIN_W + 1;    // multiplier left operand, signed
  localparam int OPW = EW + 2;                  // multiplier right operand, signed
  localparam int MW  = AWD + OPW;               // product width
  localparam int AW  = MW + 1;                  // accumulator width
  localparam int DLW = AW - vrpd_pkg::GAIN_FRAC;
  localparam int NDW = DLW + 1;

  localparam logic [DW-1:0]         ONE      = DW'(2 ** FRAC_BITS);
  localparam logic signed [NDW-1:0] ONE_ND   = NDW'(2 ** FRAC_BITS);
  localparam logic signed [AW-1:0]  RND_HALF = AW'(2 ** (vrpd_pkg::GAIN_FRAC - 1));

  // configuration
  logic [vrpd_pkg::GAIN_W-1:0]   kp_r, ki_r, kd_r;
  logic [vrpd_pkg::PERIOD_W-1:0] period_r;

  // controller state that persists across items
  logic [DW-1:0]        duty_r;
  logic signed [EW-1:0] e1_r, e2_r;

  // per-item working registers
  logic [VOLT_BITS-1:0]   real_r, set_r;
  logic [PW-1:0]          p_r;
  logic [DW-1:0]          dsh_r;
  logic [VOLT_BITS-1:0]   rem_r;
  logic [DW-1:0]          plow_r;
  logic [DW-1:0]          q_r;
  vrpd_pkg::tsel_t        tsel_r;
  logic [DW-1:0]          target_r;
  logic                   sat_r;
  logic signed [EW-1:0]   e_r;
  logic signed [EW:0]     d1_r;
  logic signed [EW+1:0]   d2_r;
  logic signed [MW-1:0]   prod_r;
  logic signed [AW-1:0]   acc_r;

  // result registers
  logic [DW-1:0]                 res_duty_r, res_target_r;
  logic [vrpd_pkg::PERIOD_W-1:0] res_pulse_r;
  logic                          res_clamped_r;

  logic [PW-1:0]           p_add_c;
  logic [VOLT_BITS-1:0]    hi_c;
  logic [VOLT_BITS:0]      div_t_c;
  logic                    div_ge_c;
  logic signed [EW-1:0]    e_c;
  logic signed [AWD-1:0]   ma_c;
  logic signed [OPW-1:0]   mb_c;
  logic signed [MW-1:0]    prod_c;
  logic signed [AW-1:0]    rnd_c;
  logic signed [DLW-1:0]   delta_c;
  logic signed [NDW-1:0]   nd_c;
  logic [DW-1:0]           nd_clip_c;
  logic                    nd_sat_c;

  // multiply step, msb first over duty bits
  assign p_add_c = {p_r[PW-2:0], 1'b0} + (dsh_r[DW-1] ? PW'(set_r) : PW'(0));

  // divide step, one quotient bit
  assign hi_c     = p_r[PW-1:DW];
  assign div_t_c  = {rem_r, plow_r[DW-1]};
  assign div_ge_c = (div_t_c >= {1'b0, real_r});

  // error
  assign e_c = $signed({1'b0, target_r}) - $signed({1'b0, duty_r});

  // shared multiplier operands
  always_comb begin
    ma_c = '0;
    mb_c = '0;
    case (cmd.mac_sel)
      vrpd_pkg::MAC_P: begin
        ma_c = $signed({1'b0, kp_r});
        mb_c = OPW'(d1_r);
      end
      vrpd_pkg::MAC_I: begin
        ma_c = $signed({1'b0, ki_r});
        mb_c = OPW'(e_r);
      end
      vrpd_pkg::MAC_D: begin
        ma_c = $signed({1'b0, kd_r});
        mb_c = d2_r;
      end
      vrpd_pkg::MAC_PWM: begin
        ma_c = $signed(AWD'(period_r));
        mb_c = $signed(OPW'(duty_r));
      end
      default: begin
        ma_c = '0;
        mb_c = '0;
      end
    endcase
  end

  assign prod_c = ma_c * mb_c;

  // round the gain sum to duty format and clamp the new duty
  assign rnd_c   = acc_r + RND_HALF;
  assign delta_c = $signed(rnd_c[AW-1:vrpd_pkg::GAIN_FRAC]);
  assign nd_c    = NDW'($signed({1'b0, duty_r})) + NDW'(delta_c);

  always_comb begin
    nd_sat_c  = 1'b0;
    nd_clip_c = nd_c[DW-1:0];
    if (nd_c < 0) begin
      nd_sat_c  = 1'b1;
      nd_clip_c = '0;
    end else if (nd_c > ONE_ND) begin
      nd_sat_c  = 1'b1;
      nd_clip_c = ONE;
    end
  end

  // configuration registers and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= vrpd_pkg::KP_RST;
      ki_r     <= vrpd_pkg::KI_RST;
      kd_r     <= vrpd_pkg::KD_RST;
      period_r <= vrpd_pkg::PERIOD_RST;
      duty_r   <= '0;
      e1_r     <= '0;
      e2_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (vrpd_pkg::reg_idx_t'(cfg_index))
          vrpd_pkg::REG_KP:         kp_r     <= cfg_data;
          vrpd_pkg::REG_KI:         ki_r     <= cfg_data;
          vrpd_pkg::REG_KD:         kd_r     <= cfg_data;
          vrpd_pkg::REG_PWM_PERIOD: period_r <= cfg_data[vrpd_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.duty_upd) begin
        duty_r <= nd_clip_c;
        e1_r   <= e_r;
        e2_r   <= e1_r;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      real_r <= meas_volt;
      set_r  <= goal_volt;
      p_r    <= '0;
      dsh_r  <= duty_r;
      sat_r  <= 1'b0;
    end
    if (cmd.mul_step) begin
      p_r   <= p_add_c;
      dsh_r <= {dsh_r[DW-2:0], 1'b0};
    end
    // pick target source and seed the divider
    if (cmd.chk) begin
      rem_r  <= hi_c;
      plow_r <= p_r[DW-1:0];
      if (set_r == '0) begin
        tsel_r <= vrpd_pkg::TS_ZERO;
      end else if (real_r == '0 || hi_c >= real_r) begin
        tsel_r <= vrpd_pkg::TS_FULL;
      end else begin
        tsel_r <= vrpd_pkg::TS_QUOT;
      end
    end
    if (cmd.div_step) begin
      rem_r  <= div_ge_c ? VOLT_BITS'(div_t_c - {1'b0, real_r}) : div_t_c[VOLT_BITS-1:0];
      q_r    <= {q_r[DW-2:0], div_ge_c};
      plow_r <= {plow_r[DW-2:0], 1'b0};
    end
    // form target, saturating at one
    if (cmd.tgt) begin
      case (tsel_r)
        vrpd_pkg::TS_ZERO: target_r <= '0;
        vrpd_pkg::TS_FULL: begin
          target_r <= ONE;
          sat_r    <= 1'b1;
        end
        vrpd_pkg::TS_QUOT: begin
          if (q_r > ONE) begin
            target_r <= ONE;
            sat_r    <= 1'b1;
          end else begin
            target_r <= q_r;
          end
        end
        default: target_r <= '0;
      endcase
    end
    // error differences
    if (cmd.err) begin
      e_r  <= e_c;
      d1_r <= (EW+1)'(e_c) - (EW+1)'(e1_r);
      d2_r <= (EW+2)'(e_c) - ((EW+2)'(e1_r) <<< 1) + (EW+2)'(e2_r);
    end
    if (cmd.mul_en) begin
      prod_r <= prod_c;
    end
    if (cmd.acc_clr) begin
      acc_r <= AW'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + AW'(prod_r);
    end
    if (cmd.duty_upd && nd_sat_c) begin
      sat_r <= 1'b1;
    end
    // result register
    if (cmd.out_ld) begin
      res_duty_r    <= duty_r;
      res_target_r  <= target_r;
      res_pulse_r   <= prod_r[FRAC_BITS +: vrpd_pkg::PERIOD_W];
      res_clamped_r <= sat_r;
    end
  end

  assign duty_level  = res_duty_r;
  assign target_duty = res_target_r;
  assign pulse_width = res_pulse_r;
  assign clamped     = res_clamped_r;

endmodule
`default_nettype wire

@@ rtl/core/voltage_ratio_pid_duty.sv @@
`default_nettype none
// channel  dir  payload                                              handshake
// in_ch    in   meas_volt, goal_volt                                 valid/ready
// out_ch   out  duty_level, target_duty, pulse_width, clamped        valid/ready
// cfg_*    in   cfg_index, cfg_data (kp, ki, kd, pwm_period)         cfg_we
//
// one item at a time: a new item is taken only after the result of the last one
// is loaded into the result register; each item runs the bit-serial set*duty
// multiply and the restoring divide, one bit each.
// synchronous active-low reset restores gains, period, duty and error history.
// a held result stalls the controller in its last state until out_ch takes it.
module voltage_ratio_pid_duty #(
  parameter int FRAC_BITS = 16,
  parameter int VOLT_BITS = 17
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  vrpd_in_if.sink                              in_ch,
  vrpd_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [vrpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vrpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  vrpd_pkg::cmd_t cmd;

  // sequencer
  vrpd_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // arithmetic and state
  vrpd_dp #(
    .FRAC_BITS (FRAC_BITS),
    .VOLT_BITS (VOLT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .meas_volt    (in_ch.meas_volt),
    .goal_volt    (in_ch.goal_volt),
    .duty_level   (out_ch.duty_level),
    .target_duty  (out_ch.target_duty),
    .pulse_width  (out_ch.pulse_width),
    .clamped      (out_ch.clamped)
  );

endmodule
`default_nettype wire
